// File: rtl/core/bare_pkg.sv
// Shared types and constants for the button auto-repeat event block.
package bare_pkg;

	localparam int NUM_BUTTONS = 3;

	localparam logic [15:0] INITIAL_DELAY_RST   = 16'd700;
	localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;
	localparam logic [NUM_BUTTONS-1:0] ACTIVE_LOW_RST = NUM_BUTTONS'(4);

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DELAY   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LOW      = 2'd2;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] pin_levels;
		logic [31:0]            now_ms;
		logic                   events_enabled;
	} bare_in_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] pressed_mask;
		logic [NUM_BUTTONS-1:0] press_events;
	} bare_out_t;

	// Timing registers shared by all lanes
	typedef struct packed {
		logic [15:0] initial_delay_ms;
		logic [15:0] repeat_interval_ms;
	} bare_timing_t;

endpackage

// File: rtl/core/bare_lane.sv
// One button lane: typematic hold state and press event decision.
module bare_lane
	import bare_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic         pressed,
	input  logic [31:0]  now_ms,
	input  bare_timing_t timing,
	output logic         fire
);

	localparam logic [1:0] HOLD_IDLE   = 2'd0;
	localparam logic [1:0] HOLD_ONCE   = 2'd1;
	localparam logic [1:0] HOLD_REPEAT = 2'd2;

	logic [1:0]  hold_q;
	logic [31:0] last_fire_q;
	logic [31:0] elapsed;
	logic [15:0] limit;

	assign elapsed = now_ms - last_fire_q;
	assign limit   = (hold_q == HOLD_ONCE) ? timing.initial_delay_ms
	                                       : timing.repeat_interval_ms;
	assign fire    = advance && pressed &&
	                 ((hold_q == HOLD_IDLE) || (elapsed > {16'd0, limit}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= HOLD_IDLE;
			last_fire_q <= '0;
		end else if (advance) begin
			if (!pressed) begin
				// release: drop repeat state
				hold_q      <= HOLD_IDLE;
				last_fire_q <= '0;
			end else if (fire) begin
				last_fire_q <= now_ms;
				hold_q      <= (hold_q == HOLD_IDLE) ? HOLD_ONCE : HOLD_REPEAT;
			end
		end
	end

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !pressed |=> hold_q == HOLD_IDLE && last_fire_q == '0)
		else $error("release did not clear lane state");

	a_first_press_fires: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pressed && hold_q == HOLD_IDLE |-> fire)
		else $error("first press did not fire");

	a_fire_stamps_time: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> last_fire_q == $past(now_ms) && hold_q != HOLD_IDLE)
		else $error("fire did not record time");

	a_hold_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(hold_q) && $stable(last_fire_q))
		else $error("lane state moved without an item");

endmodule

// File: rtl/core/bare_merge.sv
// Merge of lane results into one result item, with output register and skid stage.
module bare_merge
	import bare_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [NUM_BUTTONS-1:0] pressed_mask,
	input  logic [NUM_BUTTONS-1:0] lane_fire,
	output logic                   busy,
	output logic                   result_valid,
	input  logic                   result_stall,
	output bare_out_t              result
);

	bare_out_t merged;
	bare_out_t main_q;
	bare_out_t skid_q;
	logic      main_valid_q;
	logic      skid_valid_q;
	logic      pop;

	always_comb begin
		merged.pressed_mask = pressed_mask;
		merged.press_events = lane_fire;
	end

	assign pop          = main_valid_q && !result_stall;
	assign busy         = skid_valid_q;
	assign result_valid = main_valid_q;
	assign result       = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (!main_valid_q || pop) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!main_valid_q || pop) begin
				main_q <= merged;
			end else begin
				skid_q <= merged;
			end
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid holds an item while output is empty");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> main_valid_q)
		else $error("accepted item not presented");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> main_q == $past(skid_q))
		else $error("skid item lost on drain");

endmodule

// File: rtl/core/button_auto_repeat_events_top.sv
// Top level of the button auto-repeat event block: config registers, lanes, merge.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  sample   | sample_valid/sample_stall | pin_levels, now_ms, events_enabled
//  result   | result_valid/result_stall | pressed_mask, press_events
//  cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// One item per cycle while sample_stall is low; its result is registered in the
// output register, or the skid stage while the output is held. Each button has
// its own lane; all lanes update on an accepted item with events_enabled set,
// so the next item sees the new hold state. Lanes compare 32-bit elapsed time.
// Reset clears hold state and loads the timing and polarity defaults.
// A stalled result is held; a two-entry output buffer keeps sample_stall
// registered, and it rises only when both entries are full.
module button_auto_repeat_events_top
	import bare_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  bare_in_t               sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output bare_out_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]            cfg_data
);

	bare_timing_t           timing_q;
	logic [NUM_BUTTONS-1:0] active_low_q;
	logic [NUM_BUTTONS-1:0] pressed_mask;
	logic [NUM_BUTTONS-1:0] lane_fire;
	logic                   accept;
	logic                   advance;
	logic                   busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.initial_delay_ms   <= INITIAL_DELAY_RST;
			timing_q.repeat_interval_ms <= REPEAT_INTERVAL_RST;
			active_low_q                <= ACTIVE_LOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INITIAL_DELAY:   timing_q.initial_delay_ms   <= cfg_data;
				CFG_REPEAT_INTERVAL: timing_q.repeat_interval_ms <= cfg_data;
				CFG_ACTIVE_LOW:      active_low_q <= cfg_data[NUM_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	assign sample_stall = busy;
	assign accept       = sample_valid && !sample_stall;
	assign advance      = accept && sample.events_enabled;
	assign pressed_mask = sample.pin_levels ^ active_low_q;

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		bare_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.pressed (pressed_mask[b]),
			.now_ms  (sample.now_ms),
			.timing  (timing_q),
			.fire    (lane_fire[b])
		);
	end

	bare_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pressed_mask (pressed_mask),
		.lane_fire    (lane_fire),
		.busy         (busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
